// ===== sv/pcs_pkg.sv =====
// shared constants, types and segment tables for the piecewise cosine and sine block
`timescale 1ns / 1ps
`default_nettype none
package pcs_pkg;

  localparam int unsigned ANGLE_W    = 31;
  localparam int unsigned VALUE_W    = 8;
  localparam int unsigned NUM_STAGES = 9;

  localparam int unsigned FULL_TURN     = 36000;
  localparam int unsigned HALF_TURN     = 18000;
  localparam int unsigned THREE_QUARTER = 27000;
  localparam int unsigned QUARTER_TURN  = 9000;
  localparam int unsigned SEG_SPAN      = 1000;

  // 36000 = 32 * 1125, the low five bits pass straight through the reduction
  localparam int unsigned TURN_ODD    = 1125;
  localparam int unsigned TURN_SHIFT  = 5;
  // floor(2^36 / 1125), quotient low by at most one
  localparam logic [25:0] TURN_RECIP  = 26'd61083979;
  localparam int unsigned TURN_RSHIFT = 36;
  // ceil(2^25 / 1000), exact for products up to 17000
  localparam logic [15:0] SPAN_RECIP  = 16'd33555;
  localparam int unsigned SPAN_RSHIFT = 25;

  typedef logic [NUM_STAGES-1:0] pcs_en_t;

  // cosine times 100 at the start of each ten-degree segment
  function automatic logic [6:0] pcs_knot(input logic [3:0] seg);
    logic [6:0] k;
    unique case (seg)
      4'd0:    k = 7'd100;
      4'd1:    k = 7'd98;
      4'd2:    k = 7'd93;
      4'd3:    k = 7'd86;
      4'd4:    k = 7'd76;
      4'd5:    k = 7'd64;
      4'd6:    k = 7'd50;
      4'd7:    k = 7'd34;
      4'd8:    k = 7'd17;
      default: k = 7'd0;
    endcase
    return k;
  endfunction

  // fall of the cosine across each segment
  function automatic logic [4:0] pcs_drop(input logic [3:0] seg);
    logic [4:0] d;
    unique case (seg)
      4'd0:    d = 5'd2;
      4'd1:    d = 5'd5;
      4'd2:    d = 5'd7;
      4'd3:    d = 5'd10;
      4'd4:    d = 5'd12;
      4'd5:    d = 5'd14;
      4'd6:    d = 5'd16;
      4'd7:    d = 5'd17;
      4'd8:    d = 5'd17;
      default: d = 5'd0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

// ===== sv/pcs_reduce.sv =====
// stages 0 to 3: sine offset, magnitude and reduction modulo a full turn
`timescale 1ns / 1ps
`default_nettype none
module pcs_reduce (
  input  wire logic                            clk,
  input  wire pcs_pkg::pcs_en_t                en,
  input  wire logic [pcs_pkg::ANGLE_W-1:0]     in_angle,
  input  wire logic                            in_mode,
  output logic [15:0]                          rem
);
  import pcs_pkg::*;

  localparam int unsigned HI_W = ANGLE_W - TURN_SHIFT;

  logic signed [ANGLE_W:0]  ang_sum;
  logic        [ANGLE_W:0]  ang_abs;

  logic [ANGLE_W-1:0]       mag_r, mag_nxt;
  logic [HI_W-1:0]          hi1_r, hi2_r;
  logic [TURN_SHIFT-1:0]    lo1_r, lo2_r, lo3_r;
  logic [HI_W+25:0]         prod_r, prod_nxt;
  logic [HI_W-1:0]          qm_r, qm_nxt;
  logic [15:0]              quo;
  logic [26:0]              qm_full;
  logic [HI_W-1:0]          diff;
  logic [11:0]              r_est;
  logic [10:0]              r_fix;
  logic [15:0]              rem_r, rem_nxt;

  // stage 0: sine offset and magnitude
  always_comb begin
    ang_sum = $signed({in_angle[ANGLE_W-1], in_angle})
            + (in_mode ? (ANGLE_W+1)'(THREE_QUARTER) : '0);
    ang_abs = ang_sum[ANGLE_W] ? (ANGLE_W+1)'(-ang_sum) : ang_sum;
    mag_nxt = ang_abs[ANGLE_W-1:0];
  end

  // stage 1: reciprocal product for the quotient by 1125
  assign prod_nxt = (HI_W+26)'(mag_r[ANGLE_W-1:TURN_SHIFT]) * (HI_W+26)'(TURN_RECIP);

  // stage 2: quotient back times 1125
  always_comb begin
    quo     = prod_r[TURN_RSHIFT +: 16];
    qm_full = 27'(quo) * 27'(TURN_ODD);
    qm_nxt  = qm_full[HI_W-1:0];
  end

  // stage 3: remainder with one correction step
  always_comb begin
    diff    = hi2_r - qm_r;
    r_est   = diff[11:0];
    r_fix   = (r_est >= 12'(TURN_ODD)) ? 11'(r_est - 12'(TURN_ODD)) : r_est[10:0];
    rem_nxt = {r_fix, lo2_r};
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mag_r <= mag_nxt;
    end
    if (en[1]) begin
      prod_r <= prod_nxt;
      hi1_r  <= mag_r[ANGLE_W-1:TURN_SHIFT];
      lo1_r  <= mag_r[TURN_SHIFT-1:0];
    end
    if (en[2]) begin
      qm_r  <= qm_nxt;
      hi2_r <= hi1_r;
      lo2_r <= lo1_r;
    end
    if (en[3]) begin
      rem_r <= rem_nxt;
      lo3_r <= lo2_r;
    end
  end

  assign rem = {rem_r[15:TURN_SHIFT], lo3_r};

endmodule
`default_nettype wire

// ===== sv/pcs_interp.sv =====
// stages 4 to 8: quadrant fold, segment select and linear interpolation
`timescale 1ns / 1ps
`default_nettype none
module pcs_interp (
  input  wire logic                          clk,
  input  wire pcs_pkg::pcs_en_t              en,
  input  wire logic [15:0]                   rem,
  output logic signed [pcs_pkg::VALUE_W-1:0] value
);
  import pcs_pkg::*;

  logic [13:0]  fold_r, fold_nxt;
  logic         neg4_r, neg_nxt;
  logic [3:0]   seg_r, seg_nxt;
  logic [9:0]   off_r, off_nxt;
  logic [13:0]  base;
  logic         neg5_r, neg6_r, neg7_r;
  logic [14:0]  pd_r, pd_nxt;
  logic [6:0]   knot6_r, knot7_r;
  logic [30:0]  pq_r, pq_nxt;
  logic [5:0]   quo;
  logic [6:0]   mag;
  logic signed [VALUE_W-1:0] value_r, value_nxt;

  // stage 4: fold into the first quadrant
  always_comb begin
    neg_nxt  = 1'b0;
    fold_nxt = rem[13:0];
    priority if (rem <= 16'(QUARTER_TURN)) begin
      fold_nxt = rem[13:0];
    end else if (rem < 16'(HALF_TURN)) begin
      neg_nxt  = 1'b1;
      fold_nxt = 14'(16'(HALF_TURN) - rem);
    end else if (rem < 16'(THREE_QUARTER)) begin
      neg_nxt  = 1'b1;
      fold_nxt = 14'(rem - 16'(HALF_TURN));
    end else begin
      fold_nxt = 14'(16'(FULL_TURN) - rem);
    end
  end

  // stage 5: segment index, capped so the quarter point stays in the last segment
  always_comb begin
    seg_nxt = 4'd0;
    for (int i = 1; i <= 8; i++) begin
      if (fold_r >= 14'(i * SEG_SPAN)) begin
        seg_nxt = 4'(i);
      end
    end
    base    = 14'(seg_nxt) * 14'(SEG_SPAN);
    off_nxt = 10'(fold_r - base);
  end

  // stage 6: offset times segment drop
  assign pd_nxt = 15'(off_r) * 15'(pcs_drop(seg_r));

  // stage 7: reciprocal product for the division by the span
  assign pq_nxt = 31'(pd_r) * 31'(SPAN_RECIP);

  // stage 8: subtract from the knot and apply quadrant sign
  always_comb begin
    quo       = pq_r[SPAN_RSHIFT +: 6];
    mag       = knot7_r - 7'(quo);
    value_nxt = neg7_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      fold_r <= fold_nxt;
      neg4_r <= neg_nxt;
    end
    if (en[5]) begin
      seg_r  <= seg_nxt;
      off_r  <= off_nxt;
      neg5_r <= neg4_r;
    end
    if (en[6]) begin
      pd_r    <= pd_nxt;
      knot6_r <= pcs_knot(seg_r);
      neg6_r  <= neg5_r;
    end
    if (en[7]) begin
      pq_r    <= pq_nxt;
      knot7_r <= knot6_r;
      neg7_r  <= neg6_r;
    end
    if (en[8]) begin
      value_r <= value_nxt;
    end
  end

  assign value = value_r;

endmodule
`default_nettype wire

// ===== sv/piecewise_cosine_sine.sv =====
// Piecewise-linear cosine and sine of an angle in hundredths of a degree.
//
// Input channel: in_angle (signed, hundredths of a degree) and in_mode
// (0 cosine, 1 sine) with in_valid / in_stall. Result channel: out_value,
// the function value times 100 in -100..100, with out_valid / out_stall.
// An item is taken on a clock edge with valid high and stall low.
//
// Nine register stages: sine offset and magnitude, two multiplies for the
// remainder modulo 36000, remainder correction, quadrant fold, segment
// select, interpolation multiply, reciprocal divide by 1000, final sign.
// An item moves through the stages in that order to out_valid; one item
// per cycle is sustained while out_stall is low, since each stage has
// its own logic and no unit is shared.
//
// Each stage has its own valid bit and advances when it is empty or the
// stage after it advances, so bubbles close up under a stall. in_stall
// rises only when all nine stages hold items and out_stall is high.
// A synchronous low rst_n clears every valid bit; no items survive reset.
`timescale 1ns / 1ps
`default_nettype none
module piecewise_cosine_sine (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [pcs_pkg::ANGLE_W-1:0]   in_angle,
  input  wire logic                          in_mode,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [pcs_pkg::VALUE_W-1:0] out_value
);
  import pcs_pkg::*;

  pcs_en_t     en;
  pcs_en_t     vld_r, vld_nxt;
  logic [15:0] rem;

  // stage advances when empty or when the next one advances
  always_comb begin
    en[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || !out_stall;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (en[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int i = 1; i < NUM_STAGES; i++) begin
      if (en[i]) begin
        vld_nxt[i] = vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  pcs_reduce u_reduce (
    .clk      (clk),
    .en       (en),
    .in_angle (in_angle),
    .in_mode  (in_mode),
    .rem      (rem)
  );

  pcs_interp u_interp (
    .clk   (clk),
    .en    (en),
    .rem   (rem),
    .value (out_value)
  );

  assign in_stall  = !en[0];
  assign out_valid = vld_r[NUM_STAGES-1];

endmodule
`default_nettype wire

// ===== sv/pcs_checker.sv =====
// port-level checks for the piecewise cosine and sine block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module pcs_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic signed [pcs_pkg::VALUE_W-1:0] out_value
);
  import pcs_pkg::*;

  // results never leave the scaled range
  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_value >= -8'sd100) && (out_value <= 8'sd100))
    else $error("out_value outside -100..100");

  // input backs up only when the output is held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without a held result");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_value))
    else $error("out_value changed while stalled");

endmodule

bind piecewise_cosine_sine pcs_checker u_pcs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_value (out_value)
);
`default_nettype wire
